// ===== hdl/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the binary trie maximum-XOR block
// Key width, node table size, link packing, status codes and sequencer states.
// ----------------------------------------------------------------------------
package btmx_pkg;

    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned NODE_COUNT = 65536;
    localparam int unsigned NODE_BITS  = $clog2(NODE_COUNT);
    localparam int unsigned LINK_BITS  = 2 * NODE_BITS;
    localparam int unsigned LVL_BITS   = $clog2(KEY_BITS);
    localparam int unsigned FREE_BITS  = NODE_BITS + 1;
    localparam int unsigned NEED_BITS  = FREE_BITS + 1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_END,
        ST_QRY,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/binary_trie_max_xor.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor: binary trie of keys with maximum-XOR queries
// Inserts keys into a node table trie and answers maximum-XOR queries by
// walking one trie level per cycle from the most significant key bit down.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata            tuser
//  s_       in         key [31:0]       action [0] (0 insert, 1 query)
//  m_       out        best_xor [31:0]  status [1:0]
//
//  An insert runs from transfer to the earliest result transfer through one
//  node table access per trie level, a step to clear a new leaf, a step to
//  load the output register and the result on m_. A query has no leaf step.
//  A rejected insert or a query on an empty trie goes straight to loading the
//  output register. The next input is taken at the earliest in the cycle of
//  that result transfer.
//  The node table has one write and one registered read port; each level
//  uses one of them, which sets the per-level cost.
//  Reset is synchronous; the node table needs no clearing pass after reset.
//  A waiting result is held in the output register while the next item runs.
//
module binary_trie_max_xor
    import btmx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_BITS-1:0]  s_tdata,   // key
    input  logic [0:0]           s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [KEY_BITS-1:0]  m_tdata,   // best_xor
    output logic [1:0]           m_tuser    // status
);

    logic [LINK_BITS-1:0] node_mem [NODE_COUNT];

    state_t                state_reg, state_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [LVL_BITS-1:0]   lvl_reg, lvl_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    logic [LINK_BITS-1:0]  links_reg, links_next;
    logic                  use_mem_reg, use_mem_next;
    logic [FREE_BITS-1:0]  free_reg, free_next;
    logic                  root_clr_reg, root_clr_next;
    logic                  nonempty_reg, nonempty_next;
    logic [KEY_BITS-1:0]   best_reg, best_next;
    status_t               res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]   out_xor_reg, out_xor_next;
    status_t               out_status_reg, out_status_next;

    logic [LINK_BITS-1:0]  rd_data_reg;
    logic                  rd_en, wr_en;
    logic [NODE_BITS-1:0]  rd_addr, wr_addr;
    logic [LINK_BITS-1:0]  wr_data;

    logic [LINK_BITS-1:0]  links;
    logic                  bit_k;
    logic [NODE_BITS-1:0]  same_link, opp_link;
    logic [NEED_BITS-1:0]  free_need;
    logic                  pool_full;
    logic                  in_xfer;

    assign links     = use_mem_reg ? rd_data_reg : links_reg;
    assign bit_k     = key_reg[lvl_reg];
    assign same_link = bit_k ? links[LINK_BITS-1:NODE_BITS] : links[NODE_BITS-1:0];
    assign opp_link  = bit_k ? links[NODE_BITS-1:0] : links[LINK_BITS-1:NODE_BITS];
    assign free_need = {1'b0, free_reg} + NEED_BITS'(KEY_BITS);
    assign pool_full = free_need > NEED_BITS'(NODE_COUNT);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_xor_reg;
    assign m_tuser   = out_status_reg;

    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        lvl_next        = lvl_reg;
        node_next       = node_reg;
        links_next      = links_reg;
        use_mem_next    = use_mem_reg;
        free_next       = free_reg;
        root_clr_next   = root_clr_reg;
        nonempty_next   = nonempty_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_xor_next    = out_xor_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = node_reg;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_data         = links;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    key_next  = s_tdata;
                    lvl_next  = LVL_BITS'(KEY_BITS - 1);
                    node_next = '0;
                    best_next = '0;
                    if (s_tuser[0] == 1'b0) begin
                        if (pool_full) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_INS;
                            if (root_clr_reg) begin
                                rd_en        = 1'b1;
                                rd_addr      = '0;
                                use_mem_next = 1'b1;
                            end else begin
                                links_next    = '0;
                                use_mem_next  = 1'b0;
                                root_clr_next = 1'b1;
                            end
                        end
                    end else if (!nonempty_reg) begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end else begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        use_mem_next = 1'b1;
                        state_next   = ST_QRY;
                    end
                end
            end
            ST_INS: begin
                if (same_link != '0) begin
                    rd_en        = 1'b1;
                    rd_addr      = same_link;
                    node_next    = same_link;
                    use_mem_next = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    if (bit_k) begin
                        wr_data = {free_reg[NODE_BITS-1:0], links[NODE_BITS-1:0]};
                    end else begin
                        wr_data = {links[LINK_BITS-1:NODE_BITS], free_reg[NODE_BITS-1:0]};
                    end
                    node_next    = free_reg[NODE_BITS-1:0];
                    free_next    = free_reg + FREE_BITS'(1);
                    links_next   = '0;
                    use_mem_next = 1'b0;
                end
                lvl_next = lvl_reg - LVL_BITS'(1);
                if (lvl_reg == '0) begin
                    state_next = ST_INS_END;
                end
            end
            ST_INS_END: begin
                // A freshly allocated leaf still has to have its links cleared.
                wr_en           = !use_mem_reg;
                nonempty_next   = 1'b1;
                res_status_next = STATUS_OK;
                state_next      = ST_DONE;
            end
            ST_QRY: begin
                lvl_next = lvl_reg - LVL_BITS'(1);
                if (opp_link != '0) begin
                    best_next = best_reg | (KEY_BITS'(1) << lvl_reg);
                    rd_en     = 1'b1;
                    rd_addr   = opp_link;
                    node_next = opp_link;
                end else if (same_link != '0) begin
                    rd_en     = 1'b1;
                    rd_addr   = same_link;
                    node_next = same_link;
                end
                if (lvl_reg == '0 || (opp_link == '0 && same_link == '0)) begin
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_xor_next    = best_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_reg      <= FREE_BITS'(1);
            root_clr_reg  <= 1'b0;
            nonempty_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            use_mem_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            root_clr_reg  <= root_clr_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
            use_mem_reg   <= use_mem_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        lvl_reg        <= lvl_next;
        node_reg       <= node_next;
        links_reg      <= links_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        out_xor_reg    <= out_xor_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FREE_BITS'(NODE_COUNT))
        else $error("Node allocator ran past the end of the node table.");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("Node table read and write issued in the same cycle.");

    a_query_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QRY) |-> nonempty_reg)
        else $error("Query walk started on an empty trie.");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("Input accepted again right after a transfer.");

endmodule
